// ----- rtl/fdp_pkg.sv -----
// Shared types and helpers for the four-lane float dot product.
// Holds the binary32 rounding and packing function used by the multiplier and adder.
// Depends on nothing.
package fdp_pkg;

  localparam int unsigned Lanes     = 4;
  localparam int unsigned FpW       = 32;
  localparam logic [31:0] CanonNan  = 32'h7FC0_0000;
  localparam int unsigned SigW      = 50;

  typedef logic [FpW-1:0] fp32_t;

  // Round a nonzero value m * 2^e to binary32, round to nearest even.
  function automatic fp32_t fdp_round(input logic s, input logic [SigW-1:0] m,
                                      input logic signed [11:0] e);
    logic [5:0]            lz;
    logic [SigW-1:0]       mn;
    logic signed [11:0]    be;
    logic [5:0]            sh;
    logic [SigW-1:0]       msk;
    logic                  st;
    logic                  rnd;
    logic [30:0]           body;
    lz = 6'd0;
    for (int i = 0; i < SigW; i++) begin
      if (m[i]) lz = 6'(SigW - 1 - i);
    end
    mn = m << lz;
    be = e + 12'sd176 - $signed({6'd0, lz});
    // Below the normal range the significand slides right into the subnormal field.
    if (be < 12'sd1) begin
      if (be < -12'sd48) sh = 6'd50;
      else sh = 6'(12'sd1 - be);
      msk = ~({SigW{1'b1}} << sh);
      st  = |(mn & msk);
      mn  = (mn >> sh) | {{(SigW-1){1'b0}}, st};
      be  = 12'sd0;
    end
    if (be > 12'sd254) begin
      fdp_round = {s, 8'hFF, 23'd0};
    end else begin
      rnd  = mn[25] & ((|mn[24:0]) | mn[26]);
      // A rounding carry moves into the exponent field on its own.
      body = {be[7:0], mn[48:26]} + {30'd0, rnd};
      fdp_round = {s, body};
    end
  endfunction

endpackage

// ----- rtl/fdp_mul.sv -----
// One lane's binary32 multiplier, combinational.
// Depends on fdp_pkg for the rounding function.
module fdp_mul (
  input  fdp_pkg::fp32_t a,
  input  fdp_pkg::fp32_t b,
  output fdp_pkg::fp32_t p
);
  import fdp_pkg::*;

  logic [7:0]         ea, eb, eaf, ebf;
  logic [22:0]        fa, fb;
  logic               sgn, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [47:0]        pm;
  logic signed [11:0] e;

  assign ea     = a[30:23];
  assign eb     = b[30:23];
  assign fa     = a[22:0];
  assign fb     = b[22:0];
  assign sgn    = a[31] ^ b[31];
  assign a_nan  = (ea == 8'hFF) && (fa != 23'd0);
  assign b_nan  = (eb == 8'hFF) && (fb != 23'd0);
  assign a_inf  = (ea == 8'hFF) && (fa == 23'd0);
  assign b_inf  = (eb == 8'hFF) && (fb == 23'd0);
  assign a_zero = (ea == 8'd0) && (fa == 23'd0);
  assign b_zero = (eb == 8'd0) && (fb == 23'd0);

  // Subnormals use exponent one without the hidden bit.
  assign eaf = (ea == 8'd0) ? 8'd1 : ea;
  assign ebf = (eb == 8'd0) ? 8'd1 : eb;
  assign pm  = {(ea != 8'd0), fa} * {(eb != 8'd0), fb};
  assign e   = $signed({4'd0, eaf}) + $signed({4'd0, ebf}) - 12'sd300;

  always_comb begin
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      p = CanonNan;
    end else if (a_inf || b_inf) begin
      p = {sgn, 8'hFF, 23'd0};
    end else if (a_zero || b_zero) begin
      p = {sgn, 31'd0};
    end else begin
      p = fdp_round(sgn, {2'b00, pm}, e);
    end
  end

endmodule

// ----- rtl/fdp_add.sv -----
// Binary32 adder, combinational, used for the lane merge and the accumulators.
// Depends on fdp_pkg for the rounding function.
module fdp_add (
  input  fdp_pkg::fp32_t a,
  input  fdp_pkg::fp32_t b,
  output fdp_pkg::fp32_t s
);
  import fdp_pkg::*;

  logic [7:0]         ea, eb, eaf, ebf, e_big, e_sml;
  logic [23:0]        ma, mb, m_big, m_sml;
  logic               a_nan, b_nan, a_inf, b_inf, a_big, s_big, same;
  logic [7:0]         d;
  logic [5:0]         ds;
  logic [SigW-1:0]    x_big, x_sml, x_shf, sum;
  logic               st;
  logic signed [11:0] e;

  assign ea    = a[30:23];
  assign eb    = b[30:23];
  assign a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
  assign b_nan = (eb == 8'hFF) && (b[22:0] != 23'd0);
  assign a_inf = (ea == 8'hFF) && (a[22:0] == 23'd0);
  assign b_inf = (eb == 8'hFF) && (b[22:0] == 23'd0);
  assign eaf   = (ea == 8'd0) ? 8'd1 : ea;
  assign ebf   = (eb == 8'd0) ? 8'd1 : eb;
  assign ma    = {(ea != 8'd0), a[22:0]};
  assign mb    = {(eb != 8'd0), b[22:0]};

  // Order the operands by magnitude so the difference never goes negative.
  assign a_big = a[30:0] >= b[30:0];
  assign e_big = a_big ? eaf : ebf;
  assign e_sml = a_big ? ebf : eaf;
  assign m_big = a_big ? ma : mb;
  assign m_sml = a_big ? mb : ma;
  assign s_big = a_big ? a[31] : b[31];
  assign same  = a[31] == b[31];

  // Align the smaller operand, folding lost bits into a sticky bit.
  assign d     = e_big - e_sml;
  assign ds    = (d > 8'd31) ? 6'd31 : d[5:0];
  assign x_big = {1'b0, m_big, 25'd0};
  assign x_sml = {1'b0, m_sml, 25'd0};
  assign st    = |(x_sml & ~({SigW{1'b1}} << ds));
  assign x_shf = (x_sml >> ds) | {{(SigW-1){1'b0}}, st};
  assign sum   = same ? (x_big + x_shf) : (x_big - x_shf);
  assign e     = $signed({4'd0, e_big}) - 12'sd175;

  always_comb begin
    if (a_nan || b_nan || (a_inf && b_inf && !same)) begin
      s = CanonNan;
    end else if (a_inf) begin
      s = a;
    end else if (b_inf) begin
      s = b;
    end else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
      s = {a[31] & b[31], 31'd0};
    end else if (sum == '0) begin
      s = 32'd0;
    end else begin
      s = fdp_round(s_big, sum, e);
    end
  end

endmodule

// ----- rtl/float_dot_product_four_lane.sv -----
// Four-lane binary32 dot product: four multiplier lanes, an adder tree, four rotating accumulators.
// One beat is accepted per cycle whenever the pipeline advances.
// The accumulator add is combinational, so rotation never stalls the pipeline.
// The pipeline advances whenever the output register is empty or being taken.
// Synchronous active-low reset clears valid flags and the accumulators to +0.
// Depends on fdp_pkg, fdp_mul and fdp_add.
module float_dot_product_four_lane (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [255:0] in_tdata,  // x_lane0, x_lane1, x_lane2, x_lane3, y_lane0..y_lane3
  input  logic         in_tlast,  // final_group
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata  // dot_result
);
  import fdp_pkg::*;

  logic  adv;
  fp32_t x_r [Lanes];
  fp32_t y_r [Lanes];
  fp32_t prod [Lanes];
  fp32_t prod_r [Lanes];
  fp32_t s01, s23, s01_r, s23_r, grp, grp_r, upd;
  fp32_t psum_r [Lanes];
  fp32_t red_r [Lanes];
  fp32_t a01, a23, a01_r, a23_r, total;
  fp32_t out_data_r;
  logic  v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;
  logic  l1_r, l2_r, l3_r, l4_r;

  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Multiplier lanes.
  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    fdp_mul u_mul (.a(x_r[g]), .b(y_r[g]), .p(prod[g]));
  end

  // Merge of the lane products.
  fdp_add u_s01 (.a(prod_r[0]), .b(prod_r[1]), .s(s01));
  fdp_add u_s23 (.a(prod_r[2]), .b(prod_r[3]), .s(s23));
  fdp_add u_grp (.a(s01_r), .b(s23_r), .s(grp));
  // Accumulate into the oldest partial sum.
  fdp_add u_acc (.a(psum_r[0]), .b(grp_r), .s(upd));
  // Final reduction of the four partial sums.
  fdp_add u_a01 (.a(red_r[0]), .b(red_r[1]), .s(a01));
  fdp_add u_a23 (.a(red_r[2]), .b(red_r[3]), .s(a23));
  fdp_add u_tot (.a(a01_r), .b(a23_r), .s(total));

  // Valid and last flags along the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; out_valid_r <= 1'b0;
      l1_r <= 1'b0; l2_r <= 1'b0; l3_r <= 1'b0; l4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;  l1_r <= in_tlast;
      v2_r <= v1_r;       l2_r <= l1_r;
      v3_r <= v2_r;       l3_r <= l2_r;
      v4_r <= v3_r;       l4_r <= l3_r;
      v5_r <= v4_r && l4_r;
      v6_r <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  // Data stages; bubbles carry don't-care payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < Lanes; i++) begin
        x_r[i]    <= in_tdata[i*FpW +: FpW];
        y_r[i]    <= in_tdata[(Lanes+i)*FpW +: FpW];
        prod_r[i] <= prod[i];
      end
      s01_r <= s01;
      s23_r <= s23;
      grp_r <= grp;
      a01_r <= a01;
      a23_r <= a23;
      if (v6_r) out_data_r <= total;
    end
  end

  // Rotating accumulators; on the last beat the rotated set moves to the reduction stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Lanes; i++) psum_r[i] <= '0;
    end else if (adv && v4_r) begin
      if (l4_r) begin
        for (int i = 0; i < Lanes - 1; i++) red_r[i] <= psum_r[i+1];
        red_r[Lanes-1] <= upd;
        for (int i = 0; i < Lanes; i++) psum_r[i] <= '0;
      end else begin
        for (int i = 0; i < Lanes - 1; i++) psum_r[i] <= psum_r[i+1];
        psum_r[Lanes-1] <= upd;
      end
    end
  end

endmodule
